/* hdl/otk_pkg.sv */
`default_nettype none
package otk_pkg;

   localparam int MAX_STRING_CHARS_DEF = 64;
   localparam int MAX_DIGITS_DEF       = 8;
   localparam int PBUF_DEPTH           = 6;
   localparam int KW_COUNT             = 15;

   // token kinds
   localparam logic [4:0] TK_NEWLINE = 5'd0;
   localparam logic [4:0] TK_END     = 5'd1;
   localparam logic [4:0] TK_INT     = 5'd2;
   localparam logic [4:0] TK_DEC     = 5'd3;
   localparam logic [4:0] TK_CHAR    = 5'd4;
   localparam logic [4:0] TK_SLASH   = 5'd5;
   localparam logic [4:0] TK_V       = 5'd6;
   localparam logic [4:0] TK_F       = 5'd9;
   localparam logic [4:0] TK_G       = 5'd10;
   localparam logic [4:0] TK_O       = 5'd11;
   localparam logic [4:0] TK_S       = 5'd12;
   localparam logic [4:0] TK_NONE    = 5'd0;
   localparam logic [4:0] TK_ERROR   = 5'd26;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_UNEXPECT  = 3'd1;
   localparam logic [2:0] ERR_DIGITS    = 3'd2;
   localparam logic [2:0] ERR_POINT     = 3'd3;
   localparam logic [2:0] ERR_STRLONG   = 3'd4;

   // characters
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_COMMENT,
      MODE_PREFIX,
      MODE_NUMBER,
      MODE_STRING
   } mode_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [23:0] line_number;
      logic [26:0] integer_digits;
      logic [26:0] fraction_digits;
      logic [3:0]  fraction_count;
      logic        is_negative;
      logic [7:0]  char_value;
      logic        string_begins;
      logic [2:0]  error_code;
   } rec_type;

   // results of one item: replayed prefix characters, then up to two others
   typedef struct packed {
      logic [2:0]                  flush_n;
      logic [PBUF_DEPTH-1:0][7:0]  flush_buf;
      logic [23:0]                 flush_line;
      logic [1:0]                  gen_n;
      rec_type [1:0]               gen;
   } batch_type;

   // keyword table, obj entries first then mtl, text left aligned
   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      {"vt", 32'd0}, {"vn", 32'd0}, "mtllib", "usemtl",
      "newmtl", {"Ka", 32'd0}, {"Kd", 32'd0}, {"Ks", 32'd0}, {"Ns", 32'd0},
      "map_Ka", "map_Kd", "map_Ks", "map_Ns", {"Ni", 32'd0}, {"illum", 8'd0}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd2, 3'd2, 3'd6, 3'd6, 3'd6, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd6, 3'd6, 3'd6, 3'd6, 3'd2, 3'd5
   };
   localparam logic [4:0] KW_KIND [KW_COUNT] = '{
      5'd7, 5'd8, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
      5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25
   };
   localparam logic KW_MTL [KW_COUNT] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
      1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
   };

   function automatic logic [7:0] kw_byte(input logic [3:0] idx, input logic [2:0] pos);
      logic [47:0] t;
      t = KW_TEXT[idx] << {pos, 3'b000};
      return t[47:40];
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic str_ok(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == "_") || (c == CH_MINUS) || (c == CH_POINT);
   endfunction

   function automatic logic any_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic logic kw_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

   // single letter obj keywords, TK_NONE when not one
   function automatic logic [4:0] single_kind(input logic [7:0] c, input logic mtl);
      logic [4:0] k;
      k = TK_NONE;
      if (!mtl) begin
         case (c)
            "v":     k = TK_V;
            "f":     k = TK_F;
            "g":     k = TK_G;
            "o":     k = TK_O;
            "s":     k = TK_S;
            default: k = TK_NONE;
         endcase
      end
      return k;
   endfunction

   function automatic logic [26:0] times10_add(input logic [26:0] acc, input logic [3:0] d);
      return (acc << 3) + (acc << 1) + {23'd0, d};
   endfunction

endpackage
`default_nettype wire

/* hdl/otk_lexer.sv */
`default_nettype none
module otk_lexer #(
   parameter int MAX_STRING_CHARS = otk_pkg::MAX_STRING_CHARS_DEF,
   parameter int MAX_DIGITS       = otk_pkg::MAX_DIGITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic [7:0]        text_byte,
   input  wire logic              end_of_text,
   input  wire logic              file_kind,
   output otk_pkg::batch_type     batch
);

   otk_pkg::mode_type mode_ff, mode_in;
   logic [2:0]  kp_ff, kp_in;
   logic [7:0]  pbuf_ff [otk_pkg::PBUF_DEPTH];
   logic [7:0]  pbuf_in [otk_pkg::PBUF_DEPTH];
   logic [otk_pkg::KW_COUNT-1:0] alive_ff, alive_in;
   logic [26:0] iacc_ff, iacc_in, facc_ff, facc_in;
   logic [3:0]  ni_ff, ni_in, nf_ff, nf_in;
   logic        neg_ff, neg_in, pt_ff, pt_in;
   logic [6:0]  slen_ff, slen_in;
   logic [23:0] line_ff, line_in;

   always_comb begin
      logic [3:0]  d;
      logic [otk_pkg::KW_COUNT-1:0] mask, alive0, alive_nx;
      logic        exact_hit, run_idle;
      logic [4:0]  exact_kind, single0;
      logic [1:0]  g;
      otk_pkg::rec_type rec;

      mode_in  = mode_ff;
      kp_in    = kp_ff;
      pbuf_in  = pbuf_ff;
      alive_in = alive_ff;
      iacc_in  = iacc_ff;
      facc_in  = facc_ff;
      ni_in    = ni_ff;
      nf_in    = nf_ff;
      neg_in   = neg_ff;
      pt_in    = pt_ff;
      slen_in  = slen_ff;
      line_in  = line_ff;
      batch    = '0;
      batch.flush_line = line_ff;
      for (int j = 0; j < otk_pkg::PBUF_DEPTH; j++) batch.flush_buf[j] = pbuf_ff[j];
      g        = 2'd0;
      rec      = '0;
      run_idle = 1'b0;
      d        = 4'(text_byte - otk_pkg::CH_ZERO);

      exact_hit  = 1'b0;
      exact_kind = otk_pkg::TK_NONE;
      for (int i = otk_pkg::KW_COUNT - 1; i >= 0; i--) begin
         mask[i]     = otk_pkg::KW_MTL[i] == file_kind;
         alive0[i]   = otk_pkg::kw_byte(4'(i), 3'd0) == text_byte;
         alive_nx[i] = alive_ff[i] && (otk_pkg::KW_LEN[i] > kp_ff) &&
                       (otk_pkg::kw_byte(4'(i), kp_ff) == text_byte);
         if (alive_ff[i] && mask[i] && (otk_pkg::KW_LEN[i] == kp_ff)) begin
            exact_hit  = 1'b1;
            exact_kind = otk_pkg::KW_KIND[i];
         end
      end
      single0 = otk_pkg::single_kind(pbuf_ff[0], file_kind);

      if (end_of_text) begin
         if (mode_ff == otk_pkg::MODE_PREFIX) begin
            batch.flush_n = kp_ff;
         end else if (mode_ff == otk_pkg::MODE_NUMBER) begin
            rec = '0;
            rec.token_kind     = pt_ff ? otk_pkg::TK_DEC : otk_pkg::TK_INT;
            rec.line_number    = line_in;
            rec.integer_digits = iacc_ff;
            rec.fraction_digits = pt_ff ? facc_ff : 27'd0;
            rec.fraction_count = pt_ff ? nf_ff : 4'd0;
            rec.is_negative    = neg_ff;
            batch.gen[g[0]] = rec; g = g + 2'd1;
         end
         rec = '0;
         rec.token_kind  = otk_pkg::TK_END;
         rec.line_number = line_in;
         batch.gen[g[0]] = rec; g = g + 2'd1;
         mode_in = otk_pkg::MODE_IDLE;
         kp_in   = 3'd0;
         slen_in = 7'd0;
         line_in = 24'd0;
      end else begin
         case (mode_ff)
            otk_pkg::MODE_COMMENT: begin
               if (text_byte == otk_pkg::CH_LF) begin
                  mode_in  = otk_pkg::MODE_IDLE;
                  run_idle = 1'b1;
               end
            end
            otk_pkg::MODE_PREFIX: begin
               if ((kp_ff == 3'd1) && (single0 != otk_pkg::TK_NONE) &&
                   otk_pkg::any_space(text_byte)) begin
                  rec = '0;
                  rec.token_kind  = single0;
                  rec.line_number = line_in;
                  batch.gen[g[0]] = rec; g = g + 2'd1;
                  kp_in    = 3'd0;
                  mode_in  = otk_pkg::MODE_IDLE;
                  run_idle = 1'b1;
               end else if (exact_hit && otk_pkg::kw_space(text_byte)) begin
                  rec = '0;
                  rec.token_kind  = exact_kind;
                  rec.line_number = line_in;
                  batch.gen[g[0]] = rec; g = g + 2'd1;
                  kp_in   = 3'd0;
                  mode_in = otk_pkg::MODE_IDLE;
               end else if ((kp_ff < 3'(otk_pkg::PBUF_DEPTH)) && |(alive_nx & mask)) begin
                  pbuf_in[kp_ff] = text_byte;
                  kp_in          = kp_ff + 3'd1;
                  alive_in       = alive_nx;
               end else begin
                  // replay the failed prefix as the start of a string
                  batch.flush_n = kp_ff;
                  slen_in = ({4'd0, kp_ff} < 7'(MAX_STRING_CHARS)) ?
                            {4'd0, kp_ff} : 7'(MAX_STRING_CHARS);
                  mode_in = otk_pkg::MODE_STRING;
                  kp_in   = 3'd0;
                  if (otk_pkg::str_ok(text_byte)) begin
                     rec = '0;
                     rec.line_number = line_in;
                     rec.char_value  = text_byte;
                     if (slen_in >= 7'(MAX_STRING_CHARS)) begin
                        rec.token_kind = otk_pkg::TK_ERROR;
                        rec.error_code = otk_pkg::ERR_STRLONG;
                     end else begin
                        rec.token_kind    = otk_pkg::TK_CHAR;
                        rec.string_begins = slen_in == 7'd0;
                        slen_in = slen_in + 7'd1;
                     end
                     batch.gen[g[0]] = rec; g = g + 2'd1;
                  end else begin
                     mode_in  = otk_pkg::MODE_IDLE;
                     run_idle = 1'b1;
                  end
               end
            end
            otk_pkg::MODE_NUMBER: begin
               if (otk_pkg::is_digit(text_byte)) begin
                  if ((pt_ff && (nf_ff >= 4'(MAX_DIGITS))) ||
                      (!pt_ff && (ni_ff >= 4'(MAX_DIGITS)))) begin
                     rec = '0;
                     rec.token_kind  = otk_pkg::TK_ERROR;
                     rec.line_number = line_in;
                     rec.char_value  = text_byte;
                     rec.error_code  = otk_pkg::ERR_DIGITS;
                     batch.gen[g[0]] = rec; g = g + 2'd1;
                  end else if (pt_ff) begin
                     facc_in = otk_pkg::times10_add(facc_ff, d);
                     nf_in   = nf_ff + 4'd1;
                  end else begin
                     iacc_in = otk_pkg::times10_add(iacc_ff, d);
                     ni_in   = ni_ff + 4'd1;
                  end
               end else if (text_byte == otk_pkg::CH_POINT) begin
                  if (pt_ff) begin
                     rec = '0;
                     rec.token_kind  = otk_pkg::TK_ERROR;
                     rec.line_number = line_in;
                     rec.char_value  = text_byte;
                     rec.error_code  = otk_pkg::ERR_POINT;
                     batch.gen[g[0]] = rec; g = g + 2'd1;
                  end else begin
                     pt_in = 1'b1;
                  end
               end else begin
                  rec = '0;
                  rec.token_kind      = pt_ff ? otk_pkg::TK_DEC : otk_pkg::TK_INT;
                  rec.line_number     = line_in;
                  rec.integer_digits  = iacc_ff;
                  rec.fraction_digits = pt_ff ? facc_ff : 27'd0;
                  rec.fraction_count  = pt_ff ? nf_ff : 4'd0;
                  rec.is_negative     = neg_ff;
                  batch.gen[g[0]] = rec; g = g + 2'd1;
                  mode_in  = otk_pkg::MODE_IDLE;
                  run_idle = 1'b1;
               end
            end
            otk_pkg::MODE_STRING: begin
               if (otk_pkg::str_ok(text_byte)) begin
                  rec = '0;
                  rec.line_number = line_in;
                  rec.char_value  = text_byte;
                  if (slen_ff >= 7'(MAX_STRING_CHARS)) begin
                     rec.token_kind = otk_pkg::TK_ERROR;
                     rec.error_code = otk_pkg::ERR_STRLONG;
                  end else begin
                     rec.token_kind    = otk_pkg::TK_CHAR;
                     rec.string_begins = slen_ff == 7'd0;
                     slen_in = slen_ff + 7'd1;
                  end
                  batch.gen[g[0]] = rec; g = g + 2'd1;
               end else begin
                  mode_in  = otk_pkg::MODE_IDLE;
                  run_idle = 1'b1;
               end
            end
            default: begin
               mode_in  = otk_pkg::MODE_IDLE;
               run_idle = 1'b1;
            end
         endcase

         // byte seen between tokens
         if (run_idle) begin
            if (text_byte == otk_pkg::CH_HASH) begin
               mode_in = otk_pkg::MODE_COMMENT;
            end else if (text_byte == otk_pkg::CH_LF) begin
               line_in = line_in + 24'd1;
               rec = '0;
               rec.token_kind  = otk_pkg::TK_NEWLINE;
               rec.line_number = line_in;
               batch.gen[g[0]] = rec; g = g + 2'd1;
            end else if ((text_byte == otk_pkg::CH_SLASH) && !file_kind) begin
               rec = '0;
               rec.token_kind  = otk_pkg::TK_SLASH;
               rec.line_number = line_in;
               batch.gen[g[0]] = rec; g = g + 2'd1;
            end else if ((text_byte == otk_pkg::CH_SPACE) || (text_byte == otk_pkg::CH_CR) ||
                         (text_byte == otk_pkg::CH_TAB)) begin
               mode_in = otk_pkg::MODE_IDLE;
            end else if (otk_pkg::is_digit(text_byte) || (text_byte == otk_pkg::CH_MINUS)) begin
               mode_in = otk_pkg::MODE_NUMBER;
               facc_in = 27'd0;
               nf_in   = 4'd0;
               pt_in   = 1'b0;
               if (text_byte == otk_pkg::CH_MINUS) begin
                  neg_in  = 1'b1;
                  iacc_in = 27'd0;
                  ni_in   = 4'd0;
               end else begin
                  neg_in  = 1'b0;
                  iacc_in = {23'd0, d};
                  ni_in   = 4'd1;
               end
            end else if ((otk_pkg::single_kind(text_byte, file_kind) != otk_pkg::TK_NONE) ||
                         |(alive0 & mask)) begin
               pbuf_in[0] = text_byte;
               kp_in      = 3'd1;
               alive_in   = alive0;
               mode_in    = otk_pkg::MODE_PREFIX;
            end else if (otk_pkg::str_ok(text_byte)) begin
               mode_in = otk_pkg::MODE_STRING;
               slen_in = 7'd1;
               rec = '0;
               rec.token_kind    = otk_pkg::TK_CHAR;
               rec.line_number   = line_in;
               rec.char_value    = text_byte;
               rec.string_begins = 1'b1;
               batch.gen[g[0]] = rec; g = g + 2'd1;
            end else begin
               rec = '0;
               rec.token_kind  = otk_pkg::TK_ERROR;
               rec.line_number = line_in;
               rec.char_value  = text_byte;
               rec.error_code  = otk_pkg::ERR_UNEXPECT;
               batch.gen[g[0]] = rec; g = g + 2'd1;
            end
         end
      end
      batch.gen_n = g;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= otk_pkg::MODE_IDLE;
         kp_ff    <= 3'd0;
         alive_ff <= '0;
         iacc_ff  <= 27'd0;
         facc_ff  <= 27'd0;
         ni_ff    <= 4'd0;
         nf_ff    <= 4'd0;
         neg_ff   <= 1'b0;
         pt_ff    <= 1'b0;
         slen_ff  <= 7'd0;
         line_ff  <= 24'd0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         kp_ff    <= kp_in;
         alive_ff <= alive_in;
         iacc_ff  <= iacc_in;
         facc_ff  <= facc_in;
         ni_ff    <= ni_in;
         nf_ff    <= nf_in;
         neg_ff   <= neg_in;
         pt_ff    <= pt_in;
         slen_ff  <= slen_in;
         line_ff  <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pbuf_ff <= pbuf_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/otk_outbuf.sv */
`default_nettype none
module otk_outbuf #(
   parameter int MAX_STRING_CHARS = otk_pkg::MAX_STRING_CHARS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire otk_pkg::batch_type batch,
   output logic                    free,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output otk_pkg::rec_type        rsp_rec,
   output logic                    rsp_last
);

   logic [2:0]  flush_left_ff, flush_left_in, flush_pos_ff, flush_pos_in;
   logic [1:0]  gen_left_ff, gen_left_in;
   logic        gen_pos_ff, gen_pos_in;
   logic [otk_pkg::PBUF_DEPTH-1:0][7:0] flush_buf_ff;
   logic [23:0] flush_line_ff;
   otk_pkg::rec_type [1:0] gen_ff;
   logic        take;

   always_comb begin
      rsp_valid = (flush_left_ff != 3'd0) || (gen_left_ff != 2'd0);
      rsp_last  = ({1'b0, flush_left_ff} + {2'd0, gen_left_ff}) == 4'd1;
      take      = rsp_valid && !rsp_stall;
      free      = !rsp_valid || (take && rsp_last);
      rsp_rec   = '0;
      if (flush_left_ff != 3'd0) begin
         rsp_rec.line_number = flush_line_ff;
         rsp_rec.char_value  = flush_buf_ff[flush_pos_ff];
         // replayed characters past the string limit turn into errors
         if ({4'd0, flush_pos_ff} >= 7'(MAX_STRING_CHARS)) begin
            rsp_rec.token_kind = otk_pkg::TK_ERROR;
            rsp_rec.error_code = otk_pkg::ERR_STRLONG;
         end else begin
            rsp_rec.token_kind    = otk_pkg::TK_CHAR;
            rsp_rec.string_begins = flush_pos_ff == 3'd0;
         end
      end else begin
         rsp_rec = gen_ff[gen_pos_ff];
      end
   end

   always_comb begin
      flush_left_in = flush_left_ff;
      flush_pos_in  = flush_pos_ff;
      gen_left_in   = gen_left_ff;
      gen_pos_in    = gen_pos_ff;
      if (load) begin
         flush_left_in = batch.flush_n;
         flush_pos_in  = 3'd0;
         gen_left_in   = batch.gen_n;
         gen_pos_in    = 1'b0;
      end else if (take) begin
         if (flush_left_ff != 3'd0) begin
            flush_left_in = flush_left_ff - 3'd1;
            flush_pos_in  = flush_pos_ff + 3'd1;
         end else begin
            gen_left_in = gen_left_ff - 2'd1;
            gen_pos_in  = gen_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_left_ff <= 3'd0;
         flush_pos_ff  <= 3'd0;
         gen_left_ff   <= 2'd0;
         gen_pos_ff    <= 1'b0;
      end else begin
         flush_left_ff <= flush_left_in;
         flush_pos_ff  <= flush_pos_in;
         gen_left_ff   <= gen_left_in;
         gen_pos_ff    <= gen_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flush_buf_ff  <= batch.flush_buf;
         flush_line_ff <= batch.flush_line;
         gen_ff        <= batch.gen;
      end
   end

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset) load |-> free)
      else $error("batch loaded while results pending");
   a_flush_span: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, flush_pos_ff} + {1'b0, flush_left_ff}) <= 4'(otk_pkg::PBUF_DEPTH))
      else $error("prefix replay beyond buffer");
   a_gen_span: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, gen_pos_ff} + gen_left_ff) <= 2'd2)
      else $error("result slot overrun");
   a_keep_going: assert property (@(posedge clock) disable iff (reset)
      (take && !rsp_last) |=> rsp_valid)
      else $error("results lost before last");
`endif

endmodule
`default_nettype wire

/* hdl/obj_mtl_text_tokenizer.sv */
// OBJ / MTL text tokenizer
// req channel: one text byte per transaction, or an end-of-text mark
//   (req_end_of_text high, byte ignored). csr_write_enable loads
//   csr_write_data into the file kind register (0 obj, 1 mtl); write it only
//   while no transaction is in flight.
// rsp channel: one token per transaction; rsp_last_result marks the final
//   token caused by one input byte. A byte can cause zero to seven tokens.
// path: a byte is registered in the input register on acceptance; when the
//   lexer fires, its tokens are loaded into the result buffer and driven on rsp.
// throughput: one byte per cycle while each byte gives at most one token and
//   rsp_stall is low; a byte with more tokens holds the input until its last
//   token is taken; the result buffer sends one token a cycle unless stalled.
// stall: while rsp_stall is high the token and its fields hold, the input
//   register fills and req_stall rises; no data is lost.
// reset: synchronous, clears the lexer to idle, line count to zero, drops
//   pending tokens and selects obj keywords.
`default_nettype none
module obj_mtl_text_tokenizer #(
   parameter int MAX_STRING_CHARS = otk_pkg::MAX_STRING_CHARS_DEF,
   parameter int MAX_DIGITS       = otk_pkg::MAX_DIGITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_end_of_text,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [4:0]       rsp_token_kind,
   output logic [23:0]      rsp_line_number,
   output logic [26:0]      rsp_integer_digits,
   output logic [26:0]      rsp_fraction_digits,
   output logic [3:0]       rsp_fraction_count,
   output logic             rsp_is_negative,
   output logic [7:0]       rsp_char_value,
   output logic             rsp_string_begins,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_last_result
);

   logic       file_kind_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eot_ff;
   logic       free, fire;
   otk_pkg::batch_type batch;
   otk_pkg::rec_type   rec;

   assign fire      = in_valid_ff && free;
   assign req_stall = in_valid_ff && !free;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_kind_ff <= 1'b0;
         in_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            file_kind_ff <= csr_write_data;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_text_byte;
         in_eot_ff  <= req_end_of_text;
      end
   end

   otk_lexer #(
      .MAX_STRING_CHARS(MAX_STRING_CHARS),
      .MAX_DIGITS(MAX_DIGITS)
   ) u_lexer (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .text_byte(in_byte_ff),
      .end_of_text(in_eot_ff),
      .file_kind(file_kind_ff),
      .batch(batch)
   );

   otk_outbuf #(
      .MAX_STRING_CHARS(MAX_STRING_CHARS)
   ) u_outbuf (
      .clock(clock),
      .reset(reset),
      .load(fire),
      .batch(batch),
      .free(free),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_rec(rec),
      .rsp_last(rsp_last_result)
   );

   assign rsp_token_kind      = rec.token_kind;
   assign rsp_line_number     = rec.line_number;
   assign rsp_integer_digits  = rec.integer_digits;
   assign rsp_fraction_digits = rec.fraction_digits;
   assign rsp_fraction_count  = rec.fraction_count;
   assign rsp_is_negative     = rec.is_negative;
   assign rsp_char_value      = rec.char_value;
   assign rsp_string_begins   = rec.string_begins;
   assign rsp_error_code      = rec.error_code;

endmodule
`default_nettype wire

/* test/tb_obj_mtl_text_tokenizer.sv */
module tb_obj_mtl_text_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STR_MAX   = 64;
   localparam int DIGIT_MAX = 8;
   localparam int IDLE_LIMIT = 5000;

   typedef struct packed {
      logic [4:0]  kind;
      logic [23:0] line;
      logic [26:0] ival;
      logic [26:0] fval;
      logic [3:0]  fcnt;
      logic        neg;
      logic [7:0]  ch;
      logic        begins;
      logic [2:0]  err;
      logic        last;
   } token_type;

   typedef struct packed {
      logic       is_cfg;
      logic       cfg_val;
      logic [7:0] text;
      logic       eot;
   } byte_item_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0, csr_write_data = 0;
   logic req_valid = 0, req_stall;
   logic [7:0] req_text_byte = 0;
   logic req_end_of_text = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [4:0] rsp_token_kind;
   logic [23:0] rsp_line_number;
   logic [26:0] rsp_integer_digits, rsp_fraction_digits;
   logic [3:0] rsp_fraction_count;
   logic rsp_is_negative, rsp_string_begins, rsp_last_result;
   logic [7:0] rsp_char_value;
   logic [2:0] rsp_error_code;

   obj_mtl_text_tokenizer i_dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_text_byte(req_text_byte), .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_token_kind(rsp_token_kind), .rsp_line_number(rsp_line_number),
      .rsp_integer_digits(rsp_integer_digits),
      .rsp_fraction_digits(rsp_fraction_digits),
      .rsp_fraction_count(rsp_fraction_count), .rsp_is_negative(rsp_is_negative),
      .rsp_char_value(rsp_char_value), .rsp_string_begins(rsp_string_begins),
      .rsp_error_code(rsp_error_code), .rsp_last_result(rsp_last_result)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   logic              lx_mtl;
   otk_pkg::mode_type lx_mode;
   int                lx_prog;
   logic [7:0]        lx_pre [6];
   logic [26:0]       lx_iacc, lx_facc;
   int                lx_ni, lx_nf;
   logic              lx_neg, lx_pt;
   int                lx_slen;
   logic [23:0]       lx_line;

   token_type     tokens_expected [$];
   token_type     step_tokens [$];
   byte_item_type pending_bytes [$];

   int errors = 0;
   int mism = 0;
   int sender_idle_pct = 0, receiver_stall_pct = 0;
   bit hold_sender = 0;
   bit stim_done = 0;
   int quiet_cycles = 0;

   function automatic string kw_str(int i);
      case (i)
         0: return "vt";     1: return "vn";     2: return "mtllib"; 3: return "usemtl";
         4: return "newmtl"; 5: return "Ka";     6: return "Kd";     7: return "Ks";
         8: return "Ns";     9: return "map_Ka"; 10: return "map_Kd"; 11: return "map_Ks";
         12: return "map_Ns"; 13: return "Ni";   default: return "illum";
      endcase
   endfunction

   function automatic int kw_code(int i);
      return (i < 2) ? 7 + i : 11 + i;
   endfunction

   function automatic bit digit_c(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit name_c(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || digit_c(c) ||
             c == "_" || c == "-" || c == ".";
   endfunction

   function automatic bit ws_any(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit ws_kw(logic [7:0] c);
      return c == " " || c == 8'd9 || c == 8'd10 || c == 8'd13;
   endfunction

   function automatic int letter_kw(logic [7:0] c);
      if (lx_mtl) return -1;
      case (c)
         "v": return otk_pkg::TK_V;
         "f": return otk_pkg::TK_F;
         "g": return otk_pkg::TK_G;
         "o": return otk_pkg::TK_O;
         "s": return otk_pkg::TK_S;
         default: return -1;
      endcase
   endfunction

   // exact match or prefix match against the active keyword set
   function automatic int kw_lookup(logic [7:0] buf_in [7], int n, bit exact);
      string s;
      int lo, hi, k;
      bit ok;
      lo = lx_mtl ? 4 : 0;
      hi = lx_mtl ? 14 : 3;
      for (int i = lo; i <= hi; i++) begin
         s = kw_str(i);
         if (exact ? (s.len() != n) : (s.len() < n)) continue;
         ok = 1;
         for (k = 0; k < n; k++) if (s[k] != buf_in[k]) ok = 0;
         if (ok) return kw_code(i);
      end
      return -1;
   endfunction

   function automatic void push_token(int kind, logic [26:0] iv, logic [26:0] fv,
                                      int fc, bit ng, logic [7:0] c, bit b, int e);
      token_type t;
      if (step_tokens.size() >= 8) return;
      t.kind = 5'(kind); t.line = lx_line; t.ival = iv; t.fval = fv; t.fcnt = 4'(fc);
      t.neg = ng; t.ch = c; t.begins = b; t.err = 3'(e); t.last = 0;
      step_tokens.push_back(t);
   endfunction

   function automatic void name_char(logic [7:0] c);
      if (lx_slen >= STR_MAX) begin
         push_token(otk_pkg::TK_ERROR, 0, 0, 0, 0, c, 0, otk_pkg::ERR_STRLONG);
         return;
      end
      push_token(otk_pkg::TK_CHAR, 0, 0, 0, 0, c, lx_slen == 0, 0);
      lx_slen++;
   endfunction

   function automatic void number_out();
      push_token(lx_pt ? otk_pkg::TK_DEC : otk_pkg::TK_INT, lx_iacc, lx_pt ? lx_facc : 0,
                 lx_pt ? lx_nf : 0, lx_neg, 0, 0, 0);
   endfunction

   function automatic void number_digit(logic [7:0] c);
      if (lx_pt) begin
         if (lx_nf >= DIGIT_MAX) begin
            push_token(otk_pkg::TK_ERROR, 0, 0, 0, 0, c, 0, otk_pkg::ERR_DIGITS);
            return;
         end
         lx_facc = lx_facc * 10 + (c - "0");
         lx_nf++;
      end else begin
         if (lx_ni >= DIGIT_MAX) begin
            push_token(otk_pkg::TK_ERROR, 0, 0, 0, 0, c, 0, otk_pkg::ERR_DIGITS);
            return;
         end
         lx_iacc = lx_iacc * 10 + (c - "0");
         lx_ni++;
      end
   endfunction

   function automatic void scan_idle(logic [7:0] c);
      logic [7:0] b [7];
      b[0] = c;
      if (c == otk_pkg::CH_HASH) begin lx_mode = otk_pkg::MODE_COMMENT; return; end
      if (c == otk_pkg::CH_LF) begin
         lx_line++;
         push_token(otk_pkg::TK_NEWLINE, 0, 0, 0, 0, 0, 0, 0);
         return;
      end
      if (c == otk_pkg::CH_SLASH && !lx_mtl) begin
         push_token(otk_pkg::TK_SLASH, 0, 0, 0, 0, 0, 0, 0);
         return;
      end
      if (c == otk_pkg::CH_SPACE || c == otk_pkg::CH_CR || c == otk_pkg::CH_TAB) return;
      if (digit_c(c) || c == otk_pkg::CH_MINUS) begin
         lx_iacc = 0; lx_facc = 0; lx_ni = 0; lx_nf = 0; lx_neg = 0; lx_pt = 0;
         lx_mode = otk_pkg::MODE_NUMBER;
         if (c == otk_pkg::CH_MINUS) lx_neg = 1; else number_digit(c);
         return;
      end
      if (letter_kw(c) >= 0 || kw_lookup(b, 1, 0) >= 0) begin
         lx_pre[0] = c; lx_prog = 1; lx_mode = otk_pkg::MODE_PREFIX;
         return;
      end
      if (name_c(c)) begin
         lx_slen = 0; lx_mode = otk_pkg::MODE_STRING; name_char(c);
         return;
      end
      push_token(otk_pkg::TK_ERROR, 0, 0, 0, 0, c, 0, otk_pkg::ERR_UNEXPECT);
   endfunction

   function automatic void replay_prefix();
      lx_mode = otk_pkg::MODE_STRING; lx_slen = 0;
      for (int i = 0; i < lx_prog; i++) name_char(lx_pre[i]);
      lx_prog = 0;
   endfunction

   function automatic void scan_string(logic [7:0] c);
      if (name_c(c)) name_char(c);
      else begin lx_mode = otk_pkg::MODE_IDLE; scan_idle(c); end
   endfunction

   function automatic void scan_prefix(logic [7:0] c);
      logic [7:0] b [7];
      int k;
      int n;
      n = lx_prog;
      for (int i = 0; i < 7; i++) b[i] = (i < n) ? lx_pre[i] : 8'd0;
      if (n == 1 && letter_kw(lx_pre[0]) >= 0 && ws_any(c)) begin
         push_token(letter_kw(lx_pre[0]), 0, 0, 0, 0, 0, 0, 0);
         lx_prog = 0; lx_mode = otk_pkg::MODE_IDLE; scan_idle(c);
         return;
      end
      k = kw_lookup(b, n, 1);
      if (k >= 0 && ws_kw(c)) begin
         push_token(k, 0, 0, 0, 0, 0, 0, 0);
         lx_prog = 0; lx_mode = otk_pkg::MODE_IDLE;
         return;
      end
      if (n < 6) begin
         b[n] = c;
         if (kw_lookup(b, n + 1, 0) >= 0) begin
            lx_pre[n] = c; lx_prog = n + 1;
            return;
         end
      end
      replay_prefix();
      scan_string(c);
   endfunction

   function automatic void predict_tokens(logic [7:0] c, logic eot);
      step_tokens.delete();
      if (eot) begin
         if (lx_mode == otk_pkg::MODE_PREFIX) replay_prefix();
         else if (lx_mode == otk_pkg::MODE_NUMBER) number_out();
         push_token(otk_pkg::TK_END, 0, 0, 0, 0, 0, 0, 0);
         lx_mode = otk_pkg::MODE_IDLE; lx_prog = 0; lx_slen = 0; lx_line = 0;
      end else begin
         case (lx_mode)
            otk_pkg::MODE_COMMENT: if (c == otk_pkg::CH_LF) begin
               lx_mode = otk_pkg::MODE_IDLE; scan_idle(c);
            end
            otk_pkg::MODE_PREFIX: scan_prefix(c);
            otk_pkg::MODE_NUMBER: begin
               if (digit_c(c)) number_digit(c);
               else if (c == otk_pkg::CH_POINT) begin
                  if (lx_pt) push_token(otk_pkg::TK_ERROR, 0, 0, 0, 0, c, 0,
                                        otk_pkg::ERR_POINT);
                  else lx_pt = 1;
               end else begin
                  number_out(); lx_mode = otk_pkg::MODE_IDLE; scan_idle(c);
               end
            end
            otk_pkg::MODE_STRING: scan_string(c);
            default: begin lx_mode = otk_pkg::MODE_IDLE; scan_idle(c); end
         endcase
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1;
      foreach (step_tokens[i]) tokens_expected.push_back(step_tokens[i]);
   endfunction

   // stimulus builders
   function automatic void add_byte(logic [7:0] c);
      byte_item_type it;
      it = '{is_cfg: 0, cfg_val: 0, text: c, eot: 0};
      pending_bytes.push_back(it);
   endfunction

   function automatic void add_eot();
      byte_item_type it;
      it = '{is_cfg: 0, cfg_val: 0, text: 8'($urandom_range(0, 255)), eot: 1};
      pending_bytes.push_back(it);
   endfunction

   function automatic void add_cfg(bit v);
      byte_item_type it;
      it = '{is_cfg: 1, cfg_val: v, text: 0, eot: 0};
      pending_bytes.push_back(it);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic string rand_num();
      string s;
      int n;
      s = "";
      if ($urandom_range(0, 3) == 0) s = "-";
      n = $urandom_range(0, 10);
      for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
      if ($urandom_range(0, 1)) begin
         s = {s, "."};
         n = $urandom_range(0, 10);
         for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
      end
      return s;
   endfunction

   function automatic string rand_name();
      string s;
      string pool;
      int n;
      pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-.";
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(pool[$urandom_range(0, pool.len() - 1)])};
      return s;
   endfunction

   function automatic string rand_line(bit mtl);
      string s;
      string sep;
      int r;
      sep = ($urandom_range(0, 3) == 0) ? "\t" : " ";
      r = $urandom_range(0, 9);
      if (r < 7) begin
         if (mtl) s = kw_str($urandom_range(4, 14));
         else begin
            case ($urandom_range(0, 8))
               0: s = "v"; 1: s = "f"; 2: s = "g"; 3: s = "o"; 4: s = "s";
               default: s = kw_str($urandom_range(0, 3));
            endcase
         end
         s = {s, sep};
         for (int i = 0; i < $urandom_range(1, 3); i++) begin
            if ($urandom_range(0, 2) == 0) s = {s, rand_name(), sep};
            else if (!mtl && $urandom_range(0, 3) == 0)
               s = {s, rand_num(), "/", rand_num(), sep};
            else s = {s, rand_num(), sep};
         end
      end else if (r == 7) s = {"# ", rand_name(), " v 1"};
      else if (r == 8) s = {string'(8'(mtl ? "K" : "m")), rand_name()};
      else begin
         s = "";
         for (int i = 0; i < $urandom_range(1, 5); i++)
            s = {s, string'(8'($urandom_range(0, 255)))};
      end
      return {s, ($urandom_range(0, 4) == 0) ? "\r\n" : "\n"};
   endfunction

   // driver
   always @(posedge clock) begin
      byte_item_type it;
      if (reset) begin
         req_valid <= 0;
         csr_write_enable <= 0;
      end else begin
         csr_write_enable <= 0;
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() > 0 && pending_bytes[0].is_cfg) begin
               req_valid <= 0;
               if (!req_valid && !hold_sender) begin
                  it = pending_bytes.pop_front();
                  csr_write_enable <= 1;
                  csr_write_data <= it.cfg_val;
                  lx_mtl = it.cfg_val;
               end
            end else if (pending_bytes.size() > 0 && !hold_sender &&
                         $urandom_range(0, 99) >= sender_idle_pct) begin
               it = pending_bytes.pop_front();
               req_valid <= 1;
               req_text_byte <= it.text;
               req_end_of_text <= it.eot;
               predict_tokens(it.text, it.eot);
            end else begin
               req_valid <= 0;
               req_text_byte <= 8'($urandom_range(0, 255));
               req_end_of_text <= 1'($urandom_range(0, 1));
            end
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      token_type got, want;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (rsp_valid && !rsp_stall) begin
            got = '{kind: rsp_token_kind, line: rsp_line_number, ival: rsp_integer_digits,
                    fval: rsp_fraction_digits, fcnt: rsp_fraction_count,
                    neg: rsp_is_negative, ch: rsp_char_value, begins: rsp_string_begins,
                    err: rsp_error_code, last: rsp_last_result};
            if (tokens_expected.size() == 0) begin
               errors++;
               mism++;
               if (mism <= 10) $display("unexpected token kind=%0d ch=%0d", got.kind, got.ch);
            end else begin
               want = tokens_expected.pop_front();
               if (got !== want) begin
                  errors++;
                  mism++;
                  if (mism <= 10) begin
                     $display("mismatch exp k=%0d ln=%0d i=%0d f=%0d fc=%0d n=%0d c=%0d b=%0d e=%0d l=%0d",
                        want.kind, want.line, want.ival, want.fval, want.fcnt, want.neg,
                        want.ch, want.begins, want.err, want.last);
                     $display("         got k=%0d ln=%0d i=%0d f=%0d fc=%0d n=%0d c=%0d b=%0d e=%0d l=%0d",
                        got.kind, got.line, got.ival, got.fval, got.fcnt, got.neg,
                        got.ch, got.begins, got.err, got.last);
                  end
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   initial begin
      lx_mtl = 0; lx_mode = otk_pkg::MODE_IDLE; lx_prog = 0; lx_iacc = 0; lx_facc = 0;
      lx_ni = 0; lx_nf = 0; lx_neg = 0; lx_pt = 0; lx_slen = 0; lx_line = 0;
      foreach (lx_pre[i]) lx_pre[i] = 0;

      // directed: obj keywords, numbers, errors
      add_text("v -1.5\nvt 9\r\n/f#x\n");
      add_byte(8'd11);
      add_byte(8'd255);
      add_text("123456789.123456789.1 - vx q");
      add_eot();
      repeat (8) @(posedge clock);
      reset <= 0;
      wait (pending_bytes.size() == 0);
      wait (tokens_expected.size() == 0);

      // settle, then mtl directed
      repeat (10) @(posedge clock);
      add_cfg(1);
      add_text("newmtl m\nmap_Ks Kx illum 2");
      add_eot();
      wait (pending_bytes.size() == 0);
      wait (tokens_expected.size() == 0);
      repeat (10) @(posedge clock);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
            default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
         endcase
         add_cfg(ph[0]);
         while (pending_bytes.size() < 12) add_text(rand_line(ph[0]));
         if (ph == 4) begin
            // sender holds until every token has drained
            wait (pending_bytes.size() < 6);
            hold_sender = 1;
            wait (tokens_expected.size() == 0);
            repeat (5) @(posedge clock);
            hold_sender = 0;
         end
         add_eot();
         wait (pending_bytes.size() == 0);
         wait (tokens_expected.size() == 0);
         repeat (10) @(posedge clock);
      end
      stim_done = 1;
   end

   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (stim_done) begin
            if (errors == 0 && tokens_expected.size() == 0) $display("DONE: 0 errors");
            else $display("DONE: errors detected");
            $finish;
         end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

endmodule
